@@ rtl/l0_quadratic_interval_min_top_assert.svh @@
// Assertion macros for the L0 quadratic interval minimum block.
// Depends on nothing; included by the top level only.
`ifndef L0_QUADRATIC_INTERVAL_MIN_TOP_ASSERT_SVH
`define L0_QUADRATIC_INTERVAL_MIN_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset
`define L0QIM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("l0qim assertion failed");
// Condition in one cycle implies consequence in the next
`define L0QIM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("l0qim assertion failed");
`else
`define L0QIM_ASSERT(label, clk, rst, prop)
`define L0QIM_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ rtl/l0qim_pkg.sv @@
// Package for the L0 quadratic interval minimum block: widths, codes, types.
// Used by every module of the block.
package l0qim_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int COEF_W         = 32;
   localparam int QUAD_W         = 31;
   localparam int VAL_W          = 64;
   localparam int DIV_W          = 47;
   localparam int MUL_A_W        = 64;
   localparam int MUL_B_W        = 32;
   localparam int MUL_P_W        = 96;
   localparam int MUL_DIGIT_W    = 8;
   localparam int QF_W           = 80;
   localparam int SUM_W          = 82;
   localparam int FRAC_SHIFT     = 16;
   localparam int VTX_SHIFT      = 15;

   typedef logic [1:0] point_type;
   localparam point_type PT_VTX = 2'd0;
   localparam point_type PT_LOW = 2'd1;
   localparam point_type PT_UPP = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_PEN, S_GSQ, S_THR, S_SQ, S_QT, S_LIN, S_SUM, S_SEL, S_UPD
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DIV, OP_PEN, OP_GSQ, OP_THR, OP_SQ, OP_QT, OP_LIN,
      OP_SUM, OP_SEL, OP_UPD
   } op_type;

   typedef struct packed {
      op_type    op;
      logic      start;
      logic      capture;
      point_type point;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic last_piece;
      logic rsp_blocked;
   } status_type;

endpackage

@@ rtl/l0qim_mul.sv @@
// Shared multiplier: 64 x 32 unsigned, one 8-bit digit of b per cycle.
// Depends on l0qim_pkg.
module l0qim_mul
   import l0qim_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] product,
   output logic               done
);
   localparam int STEPS = MUL_B_W / MUL_DIGIT_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [MUL_A_W-1:0]             a_ff;
   logic [MUL_B_W-1:0]             b_ff;
   logic [MUL_P_W-1:0]             acc_ff, acc_in;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           busy_ff, done_ff;
   logic [MUL_A_W+MUL_DIGIT_W-1:0] part;

   // Multiply by the top digit and fold into the accumulator
   always_comb begin
      part   = a_ff * b_ff[MUL_B_W-1 -: MUL_DIGIT_W];
      acc_in = (acc_ff << MUL_DIGIT_W) + MUL_P_W'(part);
   end

   // Step count and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands and accumulator
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= b_ff << MUL_DIGIT_W;
      end
   end

   assign product = acc_ff;
   assign done    = done_ff;
endmodule

@@ rtl/l0qim_div.sv @@
// Restoring divider, one quotient bit per cycle, for the vertex position.
// Depends on l0qim_pkg.
module l0qim_div
   import l0qim_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [QUAD_W-1:0] divisor,
   output logic [DIV_W-1:0]  quotient,
   output logic              done
);
   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [QUAD_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [QUAD_W:0]   shifted;
   logic              ge;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;

   // Shift in the next dividend bit and trial-subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? QUAD_W'(shifted - {1'b0, dvs_ff}) : shifted[QUAD_W-1:0];
      quo_in  = {quo_ff[DIV_W-2:0], ge};
   end

   // Bit count and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

@@ rtl/l0qim_dp.sv @@
// Datapath: request registers, vertex, cost sums, selection, running minimum.
// Depends on l0qim_pkg, l0qim_mul and l0qim_div.
module l0qim_dp
   import l0qim_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               st,
   input  logic [QUAD_W-1:0]        req_quad_coef,
   input  logic signed [COEF_W-1:0] req_lin_coef,
   input  logic signed [COEF_W-1:0] req_const_coef,
   input  logic signed [COEF_W-1:0] req_lower_bound,
   input  logic signed [COEF_W-1:0] req_upper_bound,
   input  logic                     req_last_piece,
   input  logic                     csr_wr_en,
   input  logic [COEF_W-1:0]        csr_wr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [VAL_W-1:0]  rsp_best_value,
   output logic signed [COEF_W-1:0] rsp_best_point,
   output logic                     rsp_value_saturated
);
   localparam int PW = (DATA_WIDTH < COEF_W) ? DATA_WIDTH : COEF_W;
   localparam logic [DIV_W-1:0]  GMAX_Q = DIV_W'((64'd1 << (PW - 1)) - 64'd1);
   localparam logic [COEF_W-1:0] GMAX_G = COEF_W'((64'd1 << (PW - 1)) - 64'd1);
   localparam logic [COEF_W-1:0] GMIN_G = ~GMAX_G;
   localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

   logic [COEF_W-1:0]        lam_ff;
   logic [QUAD_W-1:0]        c1_ff;
   logic signed [COEF_W-1:0] c2_ff, c3_ff, lo_ff, up_ff;
   logic                     last_ff;
   logic signed [COEF_W-1:0] g_ff, vtx_ff;
   logic [VAL_W-1:0]         pen_ff, sq_ff, lin_ff;
   logic [QF_W-1:0]          qf_ff;
   logic signed [VAL_W-1:0]  val_ff [3];
   logic                     piece_sat_ff;
   logic signed [VAL_W-1:0]  sel_val_ff, best_val_ff, rsp_val_ff;
   logic signed [COEF_W-1:0] sel_pt_ff, best_pt_ff, rsp_pt_ff;
   logic                     have_ff, sticky_ff, rsp_valid_ff, rsp_sat_ff;

   logic signed [COEF_W-1:0] x_sel;
   logic [COEF_W-1:0]        xm, c2m, gm;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [MUL_P_W-1:0]       mul_p;
   logic                     mul_done, div_done;
   logic [DIV_W-1:0]         qm, qm_neg;
   logic                     c2_pos;
   logic signed [COEF_W-1:0] g_calc;
   logic signed [SUM_W-1:0]  q_term, lin_term, c3_term, pen_term, sum;
   logic                     sum_ok;
   logic signed [VAL_W-1:0]  sum_sat, min_bd, new_best;
   logic                     low_wins, vtx_wins, better;
   logic signed [COEF_W-1:0] new_pt;

   // Magnitudes of the point under evaluation, c2 and the vertex
   always_comb begin
      case (cmd.point)
         PT_VTX:  x_sel = vtx_ff;
         PT_LOW:  x_sel = lo_ff;
         default: x_sel = up_ff;
      endcase
      xm  = x_sel[COEF_W-1] ? (~x_sel + COEF_W'(1)) : x_sel;
      c2m = c2_ff[COEF_W-1] ? (~c2_ff + COEF_W'(1)) : c2_ff;
      gm  = g_ff[COEF_W-1] ? (~g_ff + COEF_W'(1)) : g_ff;
   end

   // Multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_PEN: begin
            mul_a = MUL_A_W'(lam_ff);
            mul_b = MUL_B_W'(c1_ff);
         end
         OP_GSQ: begin
            mul_a = MUL_A_W'(gm);
            mul_b = gm;
         end
         OP_THR, OP_QT: begin
            mul_a = sq_ff;
            mul_b = MUL_B_W'(c1_ff);
         end
         OP_SQ: begin
            mul_a = MUL_A_W'(xm);
            mul_b = xm;
         end
         OP_LIN: begin
            mul_a = MUL_A_W'(c2m);
            mul_b = xm;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   l0qim_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.start && (cmd.op != OP_DIV)),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p),
      .done    (mul_done)
   );

   l0qim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start && (cmd.op == OP_DIV)),
      .dividend ({c2m, {VTX_SHIFT{1'b0}}}),
      .divisor  (c1_ff),
      .quotient (qm),
      .done     (div_done)
   );

   // Vertex: quotient, negated when c2 is positive, clamped to the point range; zero if c1 is zero
   always_comb begin
      qm_neg = ~qm + DIV_W'(1);
      c2_pos = !c2_ff[COEF_W-1] && (c2_ff != '0);
      if (c1_ff == '0) begin
         g_calc = '0;
      end else if (c2_pos) begin
         g_calc = (qm > GMAX_Q + DIV_W'(1)) ? GMIN_G : qm_neg[COEF_W-1:0];
      end else begin
         g_calc = (qm > GMAX_Q) ? GMAX_G : qm[COEF_W-1:0];
      end
   end

   // Cost sum in Q48.16 and saturation to 64 bits
   always_comb begin
      q_term   = SUM_W'(qf_ff);
      lin_term = (c2_ff[COEF_W-1] ^ x_sel[COEF_W-1]) ? -SUM_W'(lin_ff) : SUM_W'(lin_ff);
      c3_term  = {{(SUM_W-COEF_W-FRAC_SHIFT){c3_ff[COEF_W-1]}}, c3_ff, {FRAC_SHIFT{1'b0}}};
      pen_term = (x_sel != '0) ? SUM_W'(pen_ff) : '0;
      sum      = q_term + lin_term + c3_term + pen_term;
      sum_ok   = (&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]);
      sum_sat  = sum_ok ? sum[VAL_W-1:0] : (sum[SUM_W-1] ? VMIN : VMAX);
   end

   // Choose among vertex and bounds; compare with the running minimum
   always_comb begin
      low_wins = val_ff[PT_LOW] <= val_ff[PT_UPP];
      min_bd   = low_wins ? val_ff[PT_LOW] : val_ff[PT_UPP];
      vtx_wins = (val_ff[PT_VTX] <= min_bd) && (vtx_ff <= up_ff) && (vtx_ff >= lo_ff);
      better   = !have_ff || (sel_val_ff < best_val_ff);
      new_best = better ? sel_val_ff : best_val_ff;
      new_pt   = better ? sel_pt_ff : best_pt_ff;
   end

   // Penalty register and response/batch control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff       <= '0;
         have_ff      <= 1'b0;
         sticky_ff    <= 1'b0;
         best_val_ff  <= '0;
         best_pt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lam_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == OP_UPD) begin
            if (last_ff) begin
               // emit and start a new batch
               rsp_valid_ff <= 1'b1;
               have_ff      <= 1'b0;
               sticky_ff    <= 1'b0;
               best_val_ff  <= '0;
               best_pt_ff   <= '0;
            end else begin
               have_ff     <= 1'b1;
               sticky_ff   <= sticky_ff | piece_sat_ff;
               best_val_ff <= new_best;
               best_pt_ff  <= new_pt;
            end
         end
      end
   end

   // Request payload, intermediate products and response payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            c1_ff        <= req_quad_coef;
            c2_ff        <= req_lin_coef;
            c3_ff        <= req_const_coef;
            lo_ff        <= req_lower_bound;
            up_ff        <= req_upper_bound;
            last_ff      <= req_last_piece;
            piece_sat_ff <= 1'b0;
         end
         OP_DIV: begin
            if (cmd.capture) g_ff <= g_calc;
         end
         OP_PEN: begin
            if (cmd.capture) pen_ff <= {mul_p[VAL_W-2:0], 1'b0};
         end
         OP_GSQ, OP_SQ: begin
            if (cmd.capture) sq_ff <= mul_p[VAL_W-1:0];
         end
         OP_THR: begin
            if (cmd.capture) begin
               vtx_ff <= (mul_p > {{(MUL_P_W-VAL_W){1'b0}}, lam_ff, {COEF_W{1'b0}}})
                         ? g_ff : '0;
            end
         end
         OP_QT: begin
            if (cmd.capture) qf_ff <= mul_p[MUL_P_W-1:FRAC_SHIFT];
         end
         OP_LIN: begin
            if (cmd.capture) lin_ff <= mul_p[VAL_W-1:0];
         end
         OP_SUM: begin
            val_ff[cmd.point] <= sum_sat;
            piece_sat_ff      <= piece_sat_ff | !sum_ok;
         end
         OP_SEL: begin
            if (vtx_wins) begin
               sel_val_ff <= val_ff[PT_VTX];
               sel_pt_ff  <= vtx_ff;
            end else if (low_wins) begin
               sel_val_ff <= val_ff[PT_LOW];
               sel_pt_ff  <= lo_ff;
            end else begin
               sel_val_ff <= val_ff[PT_UPP];
               sel_pt_ff  <= up_ff;
            end
         end
         OP_UPD: begin
            // load the response only on the last piece; hold it otherwise
            if (last_ff) begin
               rsp_val_ff <= new_best;
               rsp_pt_ff  <= new_pt;
               rsp_sat_ff <= sticky_ff | piece_sat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      st.div_done    = div_done;
      st.mul_done    = mul_done;
      st.last_piece  = last_ff;
      st.rsp_blocked = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_value      = rsp_val_ff;
   assign rsp_best_point      = rsp_pt_ff;
   assign rsp_value_saturated = rsp_sat_ff;
endmodule

@@ rtl/l0qim_ctrl.sv @@
// Controller: sequences divider, multiplier passes and selection per request.
// Depends on l0qim_pkg.
module l0qim_ctrl
   import l0qim_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);
   state_type state_ff, state_in, nxt;
   logic      issued_ff, issued_in;
   point_type point_ff, point_in;
   logic      run_unit, unit_done;

   // State, issue flag and point counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
         point_ff  <= PT_VTX;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         point_ff  <= point_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      issued_in   = issued_ff;
      point_in    = point_ff;
      nxt         = state_ff;
      run_unit    = 1'b0;
      unit_done   = st.mul_done;
      req_ready   = 1'b0;
      cmd.op      = OP_NONE;
      cmd.start   = 1'b0;
      cmd.capture = 1'b0;
      cmd.point   = point_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               point_in = PT_VTX;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op    = OP_DIV;
            unit_done = st.div_done;
            run_unit  = 1'b1;
            nxt       = S_PEN;
         end
         S_PEN: begin
            cmd.op   = OP_PEN;
            run_unit = 1'b1;
            nxt      = S_GSQ;
         end
         S_GSQ: begin
            cmd.op   = OP_GSQ;
            run_unit = 1'b1;
            nxt      = S_THR;
         end
         S_THR: begin
            cmd.op   = OP_THR;
            run_unit = 1'b1;
            nxt      = S_SQ;
         end
         S_SQ: begin
            cmd.op   = OP_SQ;
            run_unit = 1'b1;
            nxt      = S_QT;
         end
         S_QT: begin
            cmd.op   = OP_QT;
            run_unit = 1'b1;
            nxt      = S_LIN;
         end
         S_LIN: begin
            cmd.op   = OP_LIN;
            run_unit = 1'b1;
            nxt      = S_SUM;
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            if (point_ff == PT_UPP) begin
               state_in = S_SEL;
            end else begin
               point_in = point_type'(point_ff + 2'd1);
               state_in = S_SQ;
            end
         end
         S_SEL: begin
            cmd.op   = OP_SEL;
            state_in = S_UPD;
         end
         S_UPD: begin
            // on the last piece, hold while a previous response is still waiting
            if (!(st.last_piece && st.rsp_blocked)) begin
               cmd.op   = OP_UPD;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Start the divider or multiplier once, then advance on its done pulse
      if (run_unit) begin
         if (!issued_ff) begin
            cmd.start = 1'b1;
            issued_in = 1'b1;
         end else if (unit_done) begin
            cmd.capture = 1'b1;
            issued_in   = 1'b0;
            state_in    = nxt;
         end
      end
   end
endmodule

@@ rtl/l0_quadratic_interval_min_top.sv @@
// L0 quadratic interval minimum: one request per piece, result after the last piece.
// Each request runs a divider pass, twelve passes of the shared 64x32 digit multiplier
// and the load, sum, select and update steps; no new request is accepted until it is done.
// A response is presented after the update step of the last piece, which waits while the
// previous response is still pending.
// Synchronous active-high reset clears the penalty weight and the running minimum.
`include "l0_quadratic_interval_min_top_assert.svh"
module l0_quadratic_interval_min_top
   import l0qim_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [QUAD_W-1:0]        req_quad_coef,
   input  logic signed [COEF_W-1:0] req_lin_coef,
   input  logic signed [COEF_W-1:0] req_const_coef,
   input  logic signed [COEF_W-1:0] req_lower_bound,
   input  logic signed [COEF_W-1:0] req_upper_bound,
   input  logic                     req_last_piece,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [VAL_W-1:0]  rsp_best_value,
   output logic signed [COEF_W-1:0] rsp_best_point,
   output logic                     rsp_value_saturated,
   input  logic                     csr_wr_en,
   input  logic [COEF_W-1:0]        csr_wr_data
);
   cmd_type    cmd;
   status_type st;

   l0qim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   l0qim_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_quad_coef       (req_quad_coef),
      .req_lin_coef        (req_lin_coef),
      .req_const_coef      (req_const_coef),
      .req_lower_bound     (req_lower_bound),
      .req_upper_bound     (req_upper_bound),
      .req_last_piece      (req_last_piece),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_best_value      (rsp_best_value),
      .rsp_best_point      (rsp_best_point),
      .rsp_value_saturated (rsp_value_saturated)
   );

   // Busy after each accepted request
   `L0QIM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // Divider and multiplier never finish together
   `L0QIM_ASSERT(a_one_unit, clock, reset, !(st.div_done && st.mul_done))
   // A response only appears after an update step
   `L0QIM_ASSERT(a_rsp_from_upd, clock, reset, !$rose(rsp_valid) || $past(cmd.op == OP_UPD))
endmodule
